// ----- design/sfla_pkg.sv -----
// ---------------------------------------------------------------------------
// sfla_pkg: shared types and constants of the slot free list allocator
// Pool depth, derived widths, the link entry layout and the write request
// that travels to the link memory.
// ---------------------------------------------------------------------------
package sfla_pkg;

   localparam int PoolDepth = 1024;
   localparam int IdxWidth  = $clog2(PoolDepth);
   localparam int CntWidth  = $clog2(PoolDepth + 1);

   localparam logic [CntWidth-1:0] PoolDepthCnt = CntWidth'(PoolDepth);

   // operation codes carried on req_tuser
   localparam logic OpAlloc = 1'b0;
   localparam logic OpFree  = 1'b1;

   // one entry of the free chain
   typedef struct packed {
      logic                tail;
      logic [IdxWidth-1:0] link;
   } link_entry_type;

   // write request into the link memory
   typedef struct packed {
      logic                en;
      logic [IdxWidth-1:0] addr;
      link_entry_type      data;
   } link_wr_type;

   // read request into the link memory
   typedef struct packed {
      logic                en;
      logic [IdxWidth-1:0] addr;
   } link_rd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

// ----- design/sfla_link_mem.sv -----
// ---------------------------------------------------------------------------
// sfla_link_mem: link memory of the free chain
// One write port and one read port, read data registered.
// Read data holds while no read is issued.
// ---------------------------------------------------------------------------
module sfla_link_mem (
   input  logic                    clock,
   input  sfla_pkg::link_wr_type   wr,
   input  sfla_pkg::link_rd_type   rd,
   output sfla_pkg::link_entry_type rd_data
);
   import sfla_pkg::*;

   link_entry_type mem [PoolDepth];
   link_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/slot_free_list_allocator.sv -----
// ---------------------------------------------------------------------------
// slot_free_list_allocator: linked free list of a fixed slot pool
// Allocate pops the head slot, free pushes a slot back on the head, with
// live and free counts reported on every result.
// ---------------------------------------------------------------------------
//
//  channel  direction  signals                     moves
//  req      in         tvalid tready tdata tuser   one alloc or free request
//  rsp      out        tvalid tready tdata tuser   one result per request
//  csr      in         we wdata                    pool size write
//
//  on acceptance a transaction issues the read of the head entry in the link
//  memory; the exec state then uses that link to advance the head (or
//  pushes a freed slot) and loads the result register.
//  reset and each pool size write start a pass that rebuilds the chain,
//  one entry a cycle over pool_size entries (1024 after reset); no request is
//  taken meanwhile. a result that is not taken holds the following request
//  in the exec state, and the request port waits meanwhile.
// ---------------------------------------------------------------------------
module slot_free_list_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_we,
   input  logic [sfla_pkg::CntWidth-1:0] csr_wdata,   // pool_size
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // slot_index[9:0]
   input  logic                          req_tuser,   // operation
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // slot_out, live_count, free_count
   output logic [1:0]                    rsp_tuser    // granted, misuse
);
   import sfla_pkg::*;

   // control and state registers
   state_type           state_ff, state_in;
   logic                sweep_ff, sweep_in;
   logic [IdxWidth-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [CntWidth-1:0] pool_ff, pool_in;
   logic [IdxWidth-1:0] head_ff, head_in;
   logic                head_valid_ff, head_valid_in;
   logic [CntWidth-1:0] live_ff, live_in;
   logic [CntWidth-1:0] free_ff, free_in;
   logic                op_ff, op_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                granted_ff, granted_in;
   logic                misuse_ff, misuse_in;
   logic [IdxWidth-1:0] slot_ff, slot_in;
   logic [CntWidth-1:0] rsp_live_ff, rsp_live_in;
   logic [CntWidth-1:0] rsp_free_ff, rsp_free_in;

   link_wr_type    mem_wr;
   link_rd_type    mem_rd;
   link_entry_type mem_rd_data;

   logic                req_accept;
   logic                out_free;
   logic [CntWidth-1:0] pool_clamped;
   logic [CntWidth-1:0] pool_last;
   logic                sweep_at_last;

   sfla_link_mem u_link_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

   // handshakes
   assign req_tready = (state_ff == ST_IDLE) && !sweep_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // pool size clamp and chain end
   always_comb begin
      pool_clamped = csr_wdata;
      if (csr_wdata == '0) begin
         pool_clamped = CntWidth'(1);
      end else if (csr_wdata > PoolDepthCnt) begin
         pool_clamped = PoolDepthCnt;
      end
   end
   assign pool_last     = pool_ff - CntWidth'(1);
   assign sweep_at_last = ({1'b0, sweep_cnt_ff} == pool_last);

   // head read on acceptance
   always_comb begin
      mem_rd.en   = req_accept;
      mem_rd.addr = head_ff;
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      pool_in       = pool_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      live_in       = live_ff;
      free_in       = free_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      granted_in    = granted_ff;
      misuse_in     = misuse_ff;
      slot_in       = slot_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_free_in   = rsp_free_ff;
      mem_wr        = '0;

      // result taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // chain rebuild pass
      if (sweep_ff) begin
         mem_wr.en        = 1'b1;
         mem_wr.addr      = sweep_cnt_ff;
         mem_wr.data.tail = sweep_at_last;
         mem_wr.data.link = sweep_at_last ? '0 : sweep_cnt_ff + IdxWidth'(1);
         sweep_cnt_in     = sweep_cnt_ff + IdxWidth'(1);
         if (sweep_at_last) begin
            sweep_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_tuser;
               idx_in   = req_tdata[IdxWidth-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               granted_in   = 1'b0;
               misuse_in    = 1'b0;
               slot_in      = '0;
               if (op_ff == OpAlloc) begin
                  // pop the head, advance along its link
                  if (head_valid_ff && (free_ff != '0)) begin
                     granted_in = 1'b1;
                     slot_in    = head_ff;
                     if (mem_rd_data.tail) begin
                        head_valid_in = 1'b0;
                     end else begin
                        head_in = mem_rd_data.link;
                     end
                     live_in = live_ff + CntWidth'(1);
                     free_in = free_ff - CntWidth'(1);
                  end
               end else begin
                  // push the returned slot on the head
                  if ((live_ff == '0) || ({1'b0, idx_ff} >= pool_ff)) begin
                     misuse_in = 1'b1;
                  end else begin
                     mem_wr.en        = 1'b1;
                     mem_wr.addr      = idx_ff;
                     mem_wr.data.tail = !head_valid_ff;
                     mem_wr.data.link = head_ff;
                     head_in          = idx_ff;
                     head_valid_in    = 1'b1;
                     live_in          = live_ff - CntWidth'(1);
                     free_in          = free_ff + CntWidth'(1);
                  end
               end
               rsp_live_in = live_in;
               rsp_free_in = free_in;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // pool size write rebuilds the chain
      if (csr_we) begin
         pool_in       = pool_clamped;
         sweep_in      = 1'b1;
         sweep_cnt_in  = '0;
         head_in       = '0;
         head_valid_in = 1'b1;
         live_in       = '0;
         free_in       = pool_clamped;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sweep_ff      <= 1'b1;
         sweep_cnt_ff  <= '0;
         pool_ff       <= PoolDepthCnt;
         head_ff       <= '0;
         head_valid_ff <= 1'b1;
         live_ff       <= '0;
         free_ff       <= PoolDepthCnt;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         pool_ff       <= pool_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         live_ff       <= live_in;
         free_ff       <= free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      granted_ff  <= granted_in;
      misuse_ff   <= misuse_in;
      slot_ff     <= slot_in;
      rsp_live_ff <= rsp_live_in;
      rsp_free_ff <= rsp_free_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_free_ff, rsp_live_ff, slot_ff};
   assign rsp_tuser  = {misuse_ff, granted_ff};

endmodule
